@@ design/smx_pkg.sv @@
// Shared types, codes and defaults for the stack machine executor.
package smx_pkg;

  localparam int DATA_WORDS_DEF    = 1024;
  localparam int STACK_DEPTH_DEF   = 1024;
  localparam int PROGRAM_LINES_DEF = 1024;

  localparam int WORD_W      = 32;
  localparam int FUNC_W      = 4;
  localparam int IP_OUT_W    = 10;
  localparam int CNT_OUT_W   = 11;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FN_LD  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_ST  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_LDC = 4'd2;
  localparam logic [FUNC_W-1:0] FN_ADD = 4'd3;
  localparam logic [FUNC_W-1:0] FN_SUB = 4'd4;
  localparam logic [FUNC_W-1:0] FN_CMP = 4'd5;
  localparam logic [FUNC_W-1:0] FN_JMP = 4'd6;
  localparam logic [FUNC_W-1:0] FN_BR  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_RET = 4'd8;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_ADDR  = 3'd2,
    ST_OVER  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_LD, OP_ST, OP_LDC, OP_ADD, OP_SUB, OP_CMP, OP_JMP, OP_BR, OP_RET, OP_NOP
  } op_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [IP_OUT_W-1:0]      next_ip;
    logic signed [WORD_W-1:0] top_value;
    logic [CNT_OUT_W-1:0]     stack_depth;
    status_t                  status;
    logic                     halted;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] operand;
    logic              addr_ok;
    logic              tgt_ok;
  } cmd_t;

endpackage

@@ design/smx_queue.sv @@
// Small synchronous FIFO used between front and back end and on the result side.
module smx_queue #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_data,
  input  logic  pop,
  output item_t rd_data,
  output logic  full,
  output logic  empty
);
  import smx_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ design/smx_front.sv @@
// Front end: input handshake, opcode decode and range checks.
module smx_front #(
  parameter int DATA_WORDS    = smx_pkg::DATA_WORDS_DEF,
  parameter int PROGRAM_LINES = smx_pkg::PROGRAM_LINES_DEF
) (
  input  logic             in_push,
  output logic             in_full,
  input  smx_pkg::in_item_t in_data,
  input  logic             cq_full,
  output logic             cq_push,
  output smx_pkg::cmd_t    cq_data
);
  import smx_pkg::*;

  op_t op;

  assign in_full = cq_full;
  assign cq_push = in_push && !cq_full;

  always_comb begin
    unique case (in_data.func)
      FN_LD:   op = OP_LD;
      FN_ST:   op = OP_ST;
      FN_LDC:  op = OP_LDC;
      FN_ADD:  op = OP_ADD;
      FN_SUB:  op = OP_SUB;
      FN_CMP:  op = OP_CMP;
      FN_JMP:  op = OP_JMP;
      FN_BR:   op = OP_BR;
      FN_RET:  op = OP_RET;
      default: op = OP_NOP;
    endcase
  end

  always_comb begin
    cq_data.op      = op;
    cq_data.operand = in_data.operand;
    cq_data.addr_ok = ($unsigned(in_data.operand) < WORD_W'(DATA_WORDS));
    cq_data.tgt_ok  = ($unsigned(in_data.operand) < WORD_W'(PROGRAM_LINES));
  end

endmodule

@@ design/smx_back.sv @@
// Back end: operand stack, data memory, instruction pointer and execute.
module smx_back #(
  parameter int DATA_WORDS    = smx_pkg::DATA_WORDS_DEF,
  parameter int STACK_DEPTH   = smx_pkg::STACK_DEPTH_DEF,
  parameter int PROGRAM_LINES = smx_pkg::PROGRAM_LINES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cq_empty,
  input  smx_pkg::cmd_t      cq_data,
  output logic               cq_pop,
  input  logic               oq_full,
  output logic               oq_push,
  output smx_pkg::out_item_t oq_data
);
  import smx_pkg::*;

  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DA_W  = $clog2(DATA_WORDS);
  localparam int IP_W  = $clog2(PROGRAM_LINES);

  // stack entries below the top live in stk_mem; the top lives in top_r
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
  logic [WORD_W-1:0] dm_mem  [DATA_WORDS];

  bk_state_t         state_r, state_nxt;
  cmd_t              cmd_r;
  logic [IP_W-1:0]   ip_r, ip_nxt, ip_inc;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] top_r, top_nxt;
  logic [WORD_W-1:0] stk_rd_r, dm_rd_r;

  logic              fire;
  status_t           status;
  logic              push, pop, jump, halt, ok;
  logic [WORD_W-1:0] push_val, cmp_val;
  logic              stk_we, dm_we;

  always_comb begin
    unique case (state_r)
      BK_FETCH: state_nxt = cq_empty ? BK_FETCH : BK_EXEC;
      BK_EXEC:  state_nxt = oq_full ? BK_EXEC : BK_FETCH;
      default:  state_nxt = BK_FETCH;
    endcase
  end

  always_comb begin
    cq_pop = (state_r == BK_FETCH) && !cq_empty;
    fire   = (state_r == BK_EXEC) && !oq_full;
  end

  always_comb begin
    if ($signed(top_r) == $signed(stk_rd_r)) begin
      cmp_val = '0;
    end else if ($signed(top_r) > $signed(stk_rd_r)) begin
      cmp_val = WORD_W'(1);
    end else begin
      cmp_val = '1;
    end
  end

  assign ip_inc = (ip_r == IP_W'(PROGRAM_LINES - 1)) ? '0 : IP_W'(ip_r + 1'b1);

  always_comb begin
    status   = ST_OK;
    push     = 1'b0;
    pop      = 1'b0;
    jump     = 1'b0;
    halt     = 1'b0;
    push_val = cmd_r.operand;
    unique case (cmd_r.op) inside
      OP_LD: begin
        if (!cmd_r.addr_ok) status = ST_ADDR;
        else begin
          push     = 1'b1;
          push_val = dm_rd_r;
        end
      end
      OP_ST: begin
        if (!cmd_r.addr_ok) status = ST_ADDR;
        else if (cnt_r == '0) status = ST_EMPTY;
        else pop = 1'b1;
      end
      OP_LDC: push = 1'b1;
      OP_ADD, OP_SUB, OP_CMP: begin
        if (cnt_r < CNT_W'(2)) status = ST_FEW;
        else begin
          push = 1'b1;
          if (cmd_r.op == OP_ADD) push_val = WORD_W'(top_r + stk_rd_r);
          else if (cmd_r.op == OP_SUB) push_val = WORD_W'(top_r - stk_rd_r);
          else push_val = cmp_val;
        end
      end
      OP_JMP: begin
        if (!cmd_r.tgt_ok) status = ST_ADDR;
        else jump = 1'b1;
      end
      OP_BR: begin
        if (cnt_r == '0) status = ST_EMPTY;
        else if (top_r != '0) begin
          if (!cmd_r.tgt_ok) status = ST_ADDR;
          else jump = 1'b1;
        end
      end
      OP_RET: halt = 1'b1;
      default: ;
    endcase
    if (push && cnt_r == CNT_W'(STACK_DEPTH)) status = ST_OVER;
    ok = (status == ST_OK);

    ip_nxt  = !ok ? ip_r : (jump ? IP_W'(cmd_r.operand) : ip_inc);
    cnt_nxt = cnt_r;
    top_nxt = top_r;
    if (ok && push) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      top_nxt = push_val;
    end else if (ok && pop) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
      top_nxt = stk_rd_r;
    end
  end

  assign stk_we = fire && ok && push && (cnt_r != '0);
  assign dm_we  = fire && ok && pop;

  always_comb begin
    oq_push             = fire;
    oq_data.next_ip     = IP_OUT_W'(ip_nxt);
    oq_data.top_value   = (cnt_nxt == '0) ? '0 : top_nxt;
    oq_data.stack_depth = CNT_OUT_W'(cnt_nxt);
    oq_data.status      = status;
    oq_data.halted      = halt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_FETCH;
      ip_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        ip_r  <= ip_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cmd_r <= cq_data;
    end
    if (fire) begin
      top_r <= top_nxt;
    end
  end

  // second entry and data word are read while fetching, used on execute
  always_ff @(posedge clk) begin
    if (cq_pop) begin
      stk_rd_r <= stk_mem[SA_W'(cnt_r - CNT_W'(2))];
      dm_rd_r  <= dm_mem[DA_W'(cq_data.operand)];
    end
    if (stk_we) begin
      stk_mem[SA_W'(cnt_r - 1'b1)] <= top_r;
    end
    if (dm_we) begin
      dm_mem[DA_W'(cmd_r.operand)] <= top_r;
    end
  end

endmodule

@@ design/stack_machine_executor_core.sv @@
// Top level of the stack machine executor.
//
//  channel | ports                        | beat
//  --------+------------------------------+------------------------------
//  input   | in_push, in_full, in_data    | func, operand
//  result  | out_pop, out_empty, out_data | next_ip, top_value, stack_depth,
//          |                              | status, halted
//
//  The back end takes one instruction at a time: a fetch state reads the stack
//  and data memories, an execute state computes and writes back.
//  When idle, a beat passes the command queue, fetch, execute and result queue.
//  Reset clears the queues, pointer and stack count; memories hold no reset value.
//  Two-entry queues on both sides let input and result sides stall apart.
module stack_machine_executor_core #(
  parameter int DATA_WORDS    = smx_pkg::DATA_WORDS_DEF,
  parameter int STACK_DEPTH   = smx_pkg::STACK_DEPTH_DEF,
  parameter int PROGRAM_LINES = smx_pkg::PROGRAM_LINES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  smx_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output smx_pkg::out_item_t out_data
);
  import smx_pkg::*;

  logic      cq_push, cq_pop, cq_full, cq_empty;
  cmd_t      cq_wdata, cq_rdata;
  logic      oq_push, oq_full;
  out_item_t oq_wdata;

  smx_front #(
    .DATA_WORDS    (DATA_WORDS),
    .PROGRAM_LINES (PROGRAM_LINES)
  ) u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cq_data (cq_wdata)
  );

  smx_queue #(
    .item_t (cmd_t)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cq_push),
    .wr_data (cq_wdata),
    .pop     (cq_pop),
    .rd_data (cq_rdata),
    .full    (cq_full),
    .empty   (cq_empty)
  );

  smx_back #(
    .DATA_WORDS    (DATA_WORDS),
    .STACK_DEPTH   (STACK_DEPTH),
    .PROGRAM_LINES (PROGRAM_LINES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_data  (cq_rdata),
    .cq_pop   (cq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata)
  );

  smx_queue #(
    .item_t (out_item_t)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_data (oq_wdata),
    .pop     (out_pop),
    .rd_data (out_data),
    .full    (oq_full),
    .empty   (out_empty)
  );

endmodule

@@ design/smx_checker.sv @@
// Port-level checks for the stack machine executor, bound to the top level.
module smx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input smx_pkg::out_item_t out_data
);
  import smx_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_halt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.halted) |-> (out_data.status == ST_OK))
    else $error("halted beat carries an error");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.stack_depth == '0) |-> (out_data.top_value == '0))
    else $error("empty stack with nonzero top");

  a_err_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_data.status == ST_FEW || out_data.status == ST_EMPTY))
      |-> (out_data.stack_depth < CNT_OUT_W'(2)))
    else $error("operand error with enough entries");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result beat changed");

endmodule

bind stack_machine_executor_core smx_checker u_smx_checker (.*);
